### sv/tacn_pkg.sv
// Shared widths, constants and side-band type of the triangle property unit.
`timescale 1ns / 1ps
`default_nettype none
package tacn_pkg;

    // coordinate and edge widths
    localparam int CRD_W  = 32;
    localparam int DIF_W  = 33;
    localparam int PRD_W  = 66;
    localparam int CRS_W  = 67;
    localparam int MAG_W  = 65;
    // square split: high and low halves of a cross magnitude
    localparam int SQH_W  = 32;
    localparam int SQL_W  = 33;
    localparam int SQC_W  = 130;
    localparam int SQ_W   = 132;
    // square root and normalising divide
    localparam int ROOT_W = 66;
    localparam int REM_W  = 68;
    localparam int Q_W    = 31;
    localparam int AREA_W = 52;
    // centroid: floor(t / 3) by reciprocal, t below 2^34
    localparam int T_W    = 34;
    localparam int MH_W   = 17;
    localparam int MP_W   = 51;
    localparam int MACC_W = 69;
    localparam int MSH    = 35;
    localparam logic [34:0] MID_OFS = 35'h1_8000_0001;
    localparam logic [16:0] MID_MH  = 17'h1_5555;
    localparam logic [16:0] MID_ML  = 17'h0_AAAB;

    // data that rides alongside the square root and divide
    typedef struct packed {
        logic                       deg;
        logic [2:0]                 neg;
        logic [2:0][MAG_W-1:0]      mag;
        logic [2:0][CRD_W-1:0]      mid;
    } tacn_side_t;

endpackage
`default_nettype wire

### sv/tacn_front.sv
// Front pipeline: edges, cross product, centroid and squared cross length.
`timescale 1ns / 1ps
`default_nettype none
module tacn_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_vld,
    input  wire logic [8:0][tacn_pkg::CRD_W-1:0]       crd,
    output logic                                       out_vld,
    output logic [tacn_pkg::SQ_W-1:0]                  sq,
    output tacn_pkg::tacn_side_t                       side
);

    logic [6:0] vld_reg;

    logic signed [2:0][tacn_pkg::DIF_W-1:0] d1_reg, d1_next, d2_reg, d2_next;
    logic [2:0][tacn_pkg::T_W-1:0]          t_reg, t_next;
    logic signed [tacn_pkg::PRD_W-1:0]      pa_reg [3];
    logic signed [tacn_pkg::PRD_W-1:0]      pb_reg [3];
    logic signed [tacn_pkg::PRD_W-1:0]      pa_next [3];
    logic signed [tacn_pkg::PRD_W-1:0]      pb_next [3];
    logic [tacn_pkg::MP_W-1:0]              ph_reg [3];
    logic [tacn_pkg::MP_W-1:0]              pl_reg [3];
    logic [tacn_pkg::MP_W-1:0]              ph_next [3];
    logic [tacn_pkg::MP_W-1:0]              pl_next [3];
    logic [2:0][tacn_pkg::CRS_W-1:0]        c_reg, c_next;
    logic [2:0][tacn_pkg::CRD_W-1:0]        mid_reg, mid_next;
    tacn_pkg::tacn_side_t                   s4_reg, s4_next, s5_reg, s6_reg, s7_reg;
    logic [2:0][2*tacn_pkg::SQH_W-1:0]      hh_reg, hh_next;
    logic [2:0][tacn_pkg::SQH_W+tacn_pkg::SQL_W-1:0] hl_reg, hl_next;
    logic [2:0][2*tacn_pkg::SQL_W-1:0]      ll_reg, ll_next;
    logic [2:0][tacn_pkg::SQC_W-1:0]        sqc_reg, sqc_next;
    logic [tacn_pkg::SQ_W-1:0]              sq_reg, sq_next;

    // advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    // stage 1: edge vectors and offset centroid sums
    always_comb
    begin
        logic [34:0] s;
        for (int j = 0; j < 3; j++)
        begin
            d1_next[j] = {crd[3+j][31], crd[3+j]} - {crd[j][31], crd[j]};
            d2_next[j] = {crd[6+j][31], crd[6+j]} - {crd[j][31], crd[j]};
            s = {{3{crd[j][31]}}, crd[j]} + {{3{crd[3+j][31]}}, crd[3+j]}
                + {{3{crd[6+j][31]}}, crd[6+j]} + tacn_pkg::MID_OFS;
            t_next[j] = s[tacn_pkg::T_W-1:0];
        end
    end

    // stage 2: cross partial products and reciprocal products
    always_comb
    begin
        pa_next[0] = $signed(d1_reg[1]) * $signed(d2_reg[2]);
        pb_next[0] = $signed(d1_reg[2]) * $signed(d2_reg[1]);
        pa_next[1] = $signed(d1_reg[2]) * $signed(d2_reg[0]);
        pb_next[1] = $signed(d1_reg[0]) * $signed(d2_reg[2]);
        pa_next[2] = $signed(d1_reg[0]) * $signed(d2_reg[1]);
        pb_next[2] = $signed(d1_reg[1]) * $signed(d2_reg[0]);
        for (int j = 0; j < 3; j++)
        begin
            ph_next[j] = tacn_pkg::MP_W'(t_reg[j]) * tacn_pkg::MP_W'(tacn_pkg::MID_MH);
            pl_next[j] = tacn_pkg::MP_W'(t_reg[j]) * tacn_pkg::MP_W'(tacn_pkg::MID_ML);
        end
    end

    // stage 3: cross components and centroid quotient
    always_comb
    begin
        logic [tacn_pkg::MACC_W-1:0] acc;
        for (int j = 0; j < 3; j++)
        begin
            c_next[j] = {pa_reg[j][tacn_pkg::PRD_W-1], pa_reg[j]}
                        - {pb_reg[j][tacn_pkg::PRD_W-1], pb_reg[j]};
            acc = {1'b0, ph_reg[j], {tacn_pkg::MH_W{1'b0}}}
                  + tacn_pkg::MACC_W'(pl_reg[j]);
            // drop the 2^31 offset by flipping the top bit
            mid_next[j] = {~acc[tacn_pkg::MSH+31], acc[tacn_pkg::MSH+30:tacn_pkg::MSH]};
        end
    end

    // stage 4: sign and magnitude of the cross product
    always_comb
    begin
        logic [tacn_pkg::CRS_W-1:0] absv;
        s4_next.mid = mid_reg;
        for (int j = 0; j < 3; j++)
        begin
            s4_next.neg[j] = c_reg[j][tacn_pkg::CRS_W-1];
            absv = c_reg[j][tacn_pkg::CRS_W-1] ? (~c_reg[j] + 1'b1) : c_reg[j];
            s4_next.mag[j] = absv[tacn_pkg::MAG_W-1:0];
        end
        s4_next.deg = (c_reg == '0);
    end

    // stage 5: square partial products; stage 6: squares; stage 7: sum
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            hh_next[j] = s4_reg.mag[j][64:33] * s4_reg.mag[j][64:33];
            hl_next[j] = (tacn_pkg::SQH_W+tacn_pkg::SQL_W)'(s4_reg.mag[j][64:33])
                         * (tacn_pkg::SQH_W+tacn_pkg::SQL_W)'(s4_reg.mag[j][32:0]);
            ll_next[j] = (2*tacn_pkg::SQL_W)'(s4_reg.mag[j][32:0])
                         * (2*tacn_pkg::SQL_W)'(s4_reg.mag[j][32:0]);
            sqc_next[j] = {hh_reg[j], 66'b0}
                          + tacn_pkg::SQC_W'({hl_reg[j], 34'b0})
                          + tacn_pkg::SQC_W'(ll_reg[j]);
        end
        sq_next = tacn_pkg::SQ_W'(sqc_reg[0]) + tacn_pkg::SQ_W'(sqc_reg[1])
                  + tacn_pkg::SQ_W'(sqc_reg[2]);
    end

    // hold the stage data
    always_ff @(posedge clk)
    begin
        d1_reg  <= d1_next;
        d2_reg  <= d2_next;
        t_reg   <= t_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        ph_reg  <= ph_next;
        pl_reg  <= pl_next;
        c_reg   <= c_next;
        mid_reg <= mid_next;
        s4_reg  <= s4_next;
        hh_reg  <= hh_next;
        hl_reg  <= hl_next;
        ll_reg  <= ll_next;
        s5_reg  <= s4_reg;
        sqc_reg <= sqc_next;
        s6_reg  <= s5_reg;
        sq_reg  <= sq_next;
        s7_reg  <= s6_reg;
    end

    assign out_vld = vld_reg[6];
    assign sq      = sq_reg;
    assign side    = s7_reg;

endmodule
`default_nettype wire

### sv/tacn_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tacn_sqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_vld,
    input  wire logic [tacn_pkg::SQ_W-1:0]       sq,
    input  wire tacn_pkg::tacn_side_t            in_side,
    output logic                                 out_vld,
    output logic [tacn_pkg::ROOT_W-1:0]          root,
    output tacn_pkg::tacn_side_t                 out_side
);

    localparam int NST = tacn_pkg::ROOT_W;

    logic [NST-1:0]                vld_reg;
    logic [tacn_pkg::REM_W-1:0]    rem_reg  [NST];
    logic [tacn_pkg::ROOT_W-1:0]   root_reg [NST];
    logic [tacn_pkg::SQ_W-1:0]     sq_reg   [NST];
    tacn_pkg::tacn_side_t          side_reg [NST];

    // advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        localparam int PI = NST - 1 - k;
        logic [tacn_pkg::REM_W-1:0]   rem_in,  rem_next;
        logic [tacn_pkg::ROOT_W-1:0]  root_in, root_next;
        logic [tacn_pkg::SQ_W-1:0]    sq_in;
        tacn_pkg::tacn_side_t         side_in;
        logic [tacn_pkg::REM_W+1:0]   rem_sh, trial, diff;
        logic                         ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign sq_in   = sq;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sq_in   = sq_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next bit pair and try the new root bit
        always_comb
        begin
            rem_sh    = {rem_in, sq_in[2*PI+1 -: 2]};
            trial     = (tacn_pkg::REM_W+2)'({root_in, 2'b01});
            ge        = (rem_sh >= trial);
            diff      = rem_sh - trial;
            rem_next  = ge ? diff[tacn_pkg::REM_W-1:0] : rem_sh[tacn_pkg::REM_W-1:0];
            root_next = {root_in[tacn_pkg::ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            sq_reg[k]   <= sq_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign root     = root_reg[NST-1];
    assign out_side = side_reg[NST-1];

endmodule
`default_nettype wire

### sv/tacn_div.sv
// Pipelined restoring divide of the three cross components by the length.
`timescale 1ns / 1ps
`default_nettype none
module tacn_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_vld,
    input  wire logic [tacn_pkg::ROOT_W-1:0]        in_root,
    input  wire tacn_pkg::tacn_side_t               in_side,
    output logic                                    out_vld,
    output logic [tacn_pkg::ROOT_W-1:0]             out_root,
    output logic [2:0][tacn_pkg::Q_W-1:0]           quo,
    output tacn_pkg::tacn_side_t                    out_side
);

    localparam int NST = tacn_pkg::Q_W;

    logic [NST-1:0]                        vld_reg;
    logic [2:0][tacn_pkg::REM_W-1:0]       r_reg    [NST];
    logic [2:0][tacn_pkg::Q_W-1:0]         q_reg    [NST];
    logic [tacn_pkg::ROOT_W-1:0]           root_reg [NST];
    tacn_pkg::tacn_side_t                  side_reg [NST];

    // advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        logic [2:0][tacn_pkg::REM_W-1:0]   r_in, r_next;
        logic [2:0][tacn_pkg::Q_W-1:0]     q_in, q_next;
        logic [tacn_pkg::ROOT_W-1:0]       root_in;
        tacn_pkg::tacn_side_t              side_in;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int j = 0; j < 3; j++)
                begin
                    r_in[j] = tacn_pkg::REM_W'(in_side.mag[j]);
                end
            end
            assign q_in    = '0;
            assign root_in = in_root;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign r_in    = r_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // take one quotient bit per lane, then double the remainder
        always_comb
        begin
            logic [tacn_pkg::REM_W-1:0] den, diff, keep;
            logic                       ge;
            den = tacn_pkg::REM_W'(root_in);
            for (int j = 0; j < 3; j++)
            begin
                ge        = (r_in[j] >= den);
                diff      = r_in[j] - den;
                keep      = ge ? diff : r_in[j];
                r_next[j] = {keep[tacn_pkg::REM_W-2:0], 1'b0};
                q_next[j] = {q_in[j][tacn_pkg::Q_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[k]    <= r_next;
            q_reg[k]    <= q_next;
            root_reg[k] <= root_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_root = root_reg[NST-1];
    assign quo      = q_reg[NST-1];
    assign out_side = side_reg[NST-1];

endmodule
`default_nettype wire

### sv/triangle_area_centroid_normal.sv
// Top level: triangle area, centroid and unit normal, one triangle per cycle.
//
// Usage: drive the nine vertex coordinates (signed, COORD_FRAC_BITS fraction
// bits) and raise start for one cycle per triangle. busy is held low, so a
// request is taken at every clock edge with start high, back to back.
// Each request produces one result: done is high for one
// cycle with tri_area, mid_x/y/z, unit_nx/ny/nz and degenerate valid.
// The path runs through 7 front stages (edges, cross product, squares), 66
// square-root stages (one root bit each), 31 divide stages (one normal bit
// each) and the output register. Throughput is one triangle per cycle.
// The sink cannot stall; results are presented once and must be taken.
// Reset clears all valid bits so no spurious done is raised; requests in
// flight at reset are dropped. A zero cross product gives a zero normal
// with degenerate set and a zero area.
`timescale 1ns / 1ps
`default_nettype none
module triangle_area_centroid_normal #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] v1_x,
    input  wire logic signed [31:0] v1_y,
    input  wire logic signed [31:0] v1_z,
    input  wire logic signed [31:0] v2_x,
    input  wire logic signed [31:0] v2_y,
    input  wire logic signed [31:0] v2_z,
    input  wire logic signed [31:0] v3_x,
    input  wire logic signed [31:0] v3_y,
    input  wire logic signed [31:0] v3_z,
    output logic                    done,
    output logic [51:0]             tri_area,
    output logic signed [31:0]      mid_x,
    output logic signed [31:0]      mid_y,
    output logic signed [31:0]      mid_z,
    output logic signed [31:0]      unit_nx,
    output logic signed [31:0]      unit_ny,
    output logic signed [31:0]      unit_nz,
    output logic                    degenerate
);

    logic [8:0][tacn_pkg::CRD_W-1:0]     crd;
    logic                                f_vld, s_vld, d_vld;
    logic [tacn_pkg::SQ_W-1:0]           sq;
    tacn_pkg::tacn_side_t                f_side, s_side, d_side;
    logic [tacn_pkg::ROOT_W-1:0]         s_root, d_root;
    logic [2:0][tacn_pkg::Q_W-1:0]       quo;

    logic                                done_reg;
    logic [tacn_pkg::AREA_W-1:0]         area_reg, area_next;
    logic [2:0][tacn_pkg::CRD_W-1:0]     mid_reg;
    logic [2:0][tacn_pkg::CRD_W-1:0]     unit_reg, unit_next;
    logic                                deg_reg;

    assign busy = 1'b0;
    assign crd  = {v3_z, v3_y, v3_x, v2_z, v2_y, v2_x, v1_z, v1_y, v1_x};

    tacn_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start && !busy),
        .crd     (crd),
        .out_vld (f_vld),
        .sq      (sq),
        .side    (f_side)
    );

    tacn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (f_vld),
        .sq       (sq),
        .in_side  (f_side),
        .out_vld  (s_vld),
        .root     (s_root),
        .out_side (s_side)
    );

    tacn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s_vld),
        .in_root  (s_root),
        .in_side  (s_side),
        .out_vld  (d_vld),
        .out_root (d_root),
        .quo      (quo),
        .out_side (d_side)
    );

    // halve the length to get the area, saturate, and sign the normal
    always_comb
    begin
        logic [tacn_pkg::ROOT_W-1:0] area_sh;
        area_sh   = d_root >> (COORD_FRAC_BITS + 1);
        area_next = (|area_sh[tacn_pkg::ROOT_W-1:tacn_pkg::AREA_W])
                    ? {tacn_pkg::AREA_W{1'b1}} : area_sh[tacn_pkg::AREA_W-1:0];
        for (int j = 0; j < 3; j++)
        begin
            if (d_side.deg)
            begin
                unit_next[j] = '0;
            end
            else if (d_side.neg[j])
            begin
                unit_next[j] = ~tacn_pkg::CRD_W'(quo[j]) + 1'b1;
            end
            else
            begin
                unit_next[j] = tacn_pkg::CRD_W'(quo[j]);
            end
        end
    end

    // strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_vld;
        end
    end

    // hold the result payload
    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
        mid_reg  <= d_side.mid;
        unit_reg <= unit_next;
        deg_reg  <= d_side.deg;
    end

    assign done       = done_reg;
    assign tri_area   = area_reg;
    assign mid_x      = mid_reg[0];
    assign mid_y      = mid_reg[1];
    assign mid_z      = mid_reg[2];
    assign unit_nx    = unit_reg[0];
    assign unit_ny    = unit_reg[1];
    assign unit_nz    = unit_reg[2];
    assign degenerate = deg_reg;

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking bench for the triangle area, centroid and unit normal unit.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int FRAC = 16;
    localparam int LATENCY = 105;
    localparam int RANDOM_TRIS = 830;

    typedef struct {
        logic signed [31:0] crd [9];
    } tri_req_t;

    typedef struct {
        logic [51:0]        area;
        logic signed [31:0] mid [3];
        logic signed [31:0] nrm [3];
        logic               deg;
    } tri_props_t;

    logic clk, rst_n, start, busy, done;
    logic signed [31:0] crd [9];
    logic [51:0] tri_area;
    logic signed [31:0] mid_x, mid_y, mid_z, unit_nx, unit_ny, unit_nz;
    logic degenerate;
    int errors;
    tri_props_t props_pending[$];

    triangle_area_centroid_normal #(.COORD_FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .v1_x(crd[0]), .v1_y(crd[1]), .v1_z(crd[2]),
        .v2_x(crd[3]), .v2_y(crd[4]), .v2_z(crd[5]),
        .v3_x(crd[6]), .v3_y(crd[7]), .v3_z(crd[8]),
        .done(done), .tri_area(tri_area),
        .mid_x(mid_x), .mid_y(mid_y), .mid_z(mid_z),
        .unit_nx(unit_nx), .unit_ny(unit_ny), .unit_nz(unit_nz),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, floor, of a 132-bit value
    function automatic logic [65:0] isqrt(input logic [131:0] v);
        logic [65:0] r;
        logic [65:0] c;
        r = '0;
        for (int b = 65; b >= 0; b--)
        begin
            c = r | (66'd1 << b);
            if (132'(c) * 132'(c) <= v)
                r = c;
        end
        return r;
    endfunction

    // Round-to-nearest mean of three coordinates
    function automatic logic signed [31:0] vertex_mean(input logic signed [31:0] a,
            input logic signed [31:0] b, input logic signed [31:0] c);
        longint s;
        s = longint'(a) + longint'(b) + longint'(c) + 1 + 64'sd6442450944;
        return 32'(s / 3 - 64'sd2147483648);
    endfunction

    // Predict area, centroid and normal of one triangle
    function automatic tri_props_t triangle_props(input tri_req_t t);
        tri_props_t p;
        logic signed [32:0] e1 [3];
        logic signed [32:0] e2 [3];
        logic signed [66:0] cr [3];
        logic [65:0] mag;
        logic [131:0] sq;
        logic [65:0] root;
        logic [95:0] q;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = 33'(t.crd[3+i]) - 33'(t.crd[i]);
            e2[i] = 33'(t.crd[6+i]) - 33'(t.crd[i]);
            p.mid[i] = vertex_mean(t.crd[i], t.crd[3+i], t.crd[6+i]);
        end
        cr[0] = 67'(e1[1]) * 67'(e2[2]) - 67'(e1[2]) * 67'(e2[1]);
        cr[1] = 67'(e1[2]) * 67'(e2[0]) - 67'(e1[0]) * 67'(e2[2]);
        cr[2] = 67'(e1[0]) * 67'(e2[1]) - 67'(e1[1]) * 67'(e2[0]);
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag = cr[i] < 0 ? 66'(-cr[i]) : 66'(cr[i]);
            sq += 132'(mag) * 132'(mag);
        end
        root = isqrt(sq);
        p.area = ((root >> (FRAC + 1)) > 66'hF_FFFF_FFFF_FFFF) ? 52'hF_FFFF_FFFF_FFFF
                                                               : 52'(root >> (FRAC + 1));
        p.deg = (sq == '0);
        for (int i = 0; i < 3; i++)
        begin
            if (p.deg)
                p.nrm[i] = '0;
            else
            begin
                mag = cr[i] < 0 ? 66'(-cr[i]) : 66'(cr[i]);
                q = 96'((132'(mag) << 30) / 132'(root));
                p.nrm[i] = cr[i] < 0 ? -32'(q) : 32'(q);
            end
        end
        return p;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
            input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // Check each result strobe against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (props_pending.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                tri_props_t e;
                e = props_pending.pop_front();
                compare_field("tri_area", 64'(e.area), 64'(tri_area));
                compare_field("mid_x", 64'(e.mid[0]), 64'(mid_x));
                compare_field("mid_y", 64'(e.mid[1]), 64'(mid_y));
                compare_field("mid_z", 64'(e.mid[2]), 64'(mid_z));
                compare_field("unit_nx", 64'(e.nrm[0]), 64'(unit_nx));
                compare_field("unit_ny", 64'(e.nrm[1]), 64'(unit_ny));
                compare_field("unit_nz", 64'(e.nrm[2]), 64'(unit_nz));
                compare_field("degenerate", 64'(e.deg), 64'(degenerate));
            end
        end
    end

    // Drive one request, holding start across bursts
    int burst_left;
    task automatic send_tri(input tri_req_t t, input bit typed, input tri_props_t known);
        tri_props_t p;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        for (int i = 0; i < 9; i++)
            crd[i] <= t.crd[i];
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = typed ? known : triangle_props(t);
        props_pending.push_back(p);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_crd();
        case ($urandom_range(0, 4))
            0: return 32'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return 32'(int'($urandom_range(0, 2000)) - 1000) <<< FRAC;
            default: return 32'(int'($urandom_range(0, 131072)) - 65536) <<< 8;
        endcase
    endfunction

    localparam int N_DIR = 8;
    logic signed [31:0] dir_tab [N_DIR][9] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
        '{0, 0, 0, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0},
        '{0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
          32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000},
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF},
        '{1, -1, 1, -1, 1, -1, 2, 2, -2}
    };
    // rows with a known answer: all-zero and coincident vertices
    bit dir_typed [N_DIR] = '{1, 1, 1, 0, 0, 0, 0, 0};

    initial
    begin
        tri_req_t t;
        tri_props_t k;
        int waited;
        errors = 0;
        burst_left = 0;
        start = 1'b0;
        rst_n = 1'b0;
        for (int i = 0; i < 9; i++)
            crd[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        for (int r = 0; r < N_DIR; r++)
        begin
            for (int i = 0; i < 9; i++)
                t.crd[i] = dir_tab[r][i];
            k.area = '0;
            k.deg = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                k.mid[i] = dir_tab[r][i];
                k.nrm[i] = '0;
            end
            send_tri(t, dir_typed[r], k);
        end

        // Random triangles, with degenerate and shared-vertex ones mixed in
        for (int n = 0; n < RANDOM_TRIS; n++)
        begin
            for (int i = 0; i < 9; i++)
                t.crd[i] = rand_crd();
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 3; i++)
                    t.crd[6+i] = t.crd[3+i];
            send_tri(t, 1'b0, k);
        end
        start <= 1'b0;

        waited = 0;
        while (props_pending.size() != 0 && waited < 10 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        if (props_pending.size() != 0)
        begin
            $error("predictions left over: %0d", props_pending.size());
            errors++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

### triangle_area_centroid_normal.f
sv/tacn_pkg.sv
sv/tacn_front.sv
sv/tacn_sqrt.sv
sv/tacn_div.sv
sv/triangle_area_centroid_normal.sv
verif/tb.sv
